/* rtl/ring_buffer_deque_macros.svh */
// Assertion helpers shared by the deque RTL. Each check is sampled on the
// rising clock edge and is disabled while reset is asserted.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ring_buffer_deque: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ring_buffer_deque: next-cycle check failed");

`endif

/* rtl/rbd_pkg.sv */
`timescale 1ns / 1ps

package rbd_pkg;

	// Width of the signed position field of an input word.
	localparam int POS_W = 6;
	// Opcode field width, carried in tuser.
	localparam int OP_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_READ       = 3'd4,
		OP_WRITE      = 3'd5,
		OP_CLEAR      = 3'd6,
		OP_RESIZE     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

endpackage

/* rtl/ring_buffer_deque.sv */
// Fixed-capacity double-ended queue held in a DEPTH-entry circular RAM with a
// head pointer and an element count. Each input word carries an opcode in
// tuser (push or pop at either end, signed indexed read or write, clear,
// resize with fill) and produces exactly one result word reporting the read
// data, the front and back elements, the count, an empty flag and a status
// in tuser. Most operations pass through the RAM access of the operation
// together with the front/back lookup, then the capture of the registered
// RAM read into the output register, where the next word is already
// accepted. A resize that grows the queue fills the new slots between the
// two, one new slot per cycle through the single RAM write port, before the
// front/back lookup. The RAM contents are not cleared after reset; only the
// head pointer and count are. A result waiting on m_tready holds the block
// once the following word has finished its RAM access.
`timescale 1ns / 1ps
`include "ring_buffer_deque_macros.svh"

module ring_buffer_deque
	import rbd_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 s_tvalid,
	output logic                                                 s_tready,
	// value [DATA_WIDTH-1:0], position [+6], zero padding to whole bytes
	input  logic [((DATA_WIDTH+POS_W+7)/8)*8-1:0]                s_tdata,
	// opcode [2:0], zero padding
	input  logic [7:0]                                           s_tuser,
	output logic                                                 m_tvalid,
	input  logic                                                 m_tready,
	// read_data, front_value, back_value (DATA_WIDTH each), element_count,
	// is_empty, zero padding to whole bytes
	output logic [((3*DATA_WIDTH+$clog2(DEPTH+1)+1+7)/8)*8-1:0] m_tdata,
	// status [1:0], zero padding
	output logic [7:0]                                           m_tuser
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH+1);
	localparam int DW    = DATA_WIDTH;
	localparam int OUT_W = ((3*DW+CW+1+7)/8)*8;
	localparam int CMPW  = (CW > POS_W+1) ? CW : POS_W+1;
	localparam logic [AW:0]     DEPTH_X  = (AW+1)'(DEPTH);
	localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH-1);
	localparam logic [CW-1:0]   FULL_CNT = CW'(DEPTH);
	localparam logic [CMPW-1:0] DEPTH_C  = CMPW'(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_LOOK,
		ST_RESP
	} state_t;

	// Circular add of two slot offsets whose sum stays below twice the depth.
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
			input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[AW-1:0];
	endfunction

	state_t            state_q;
	op_t               op_q;
	logic [DW-1:0]     val_q;
	logic [POS_W-1:0]  pos_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     fill_q;
	status_t           status_q;
	logic              use_regs_q;
	logic              rd_ok_q;
	logic              fwd_a_q;
	logic              fwd_b_q;
	logic [DW-1:0]     fwd_val_q;
	logic [DW-1:0]     front_q;
	logic [DW-1:0]     back_q;

	logic              m_valid_q;
	logic [DW-1:0]     out_rd_q;
	logic [DW-1:0]     out_front_q;
	logic [DW-1:0]     out_back_q;
	logic [CW-1:0]     out_count_q;
	logic              out_empty_q;
	status_t           out_status_q;

	// Operation decode for the execute cycle.
	logic              ex_we;
	logic [AW-1:0]     ex_waddr;
	logic              ex_re;
	logic [AW-1:0]     ex_ra;
	logic [AW-1:0]     ex_rb;
	logic [AW-1:0]     ex_head;
	logic [CW-1:0]     ex_count;
	logic [CW-1:0]     ex_cnt_m1;
	status_t           ex_status;
	logic              ex_use_regs;
	logic              ex_grow;

	logic              pos_neg;
	logic [POS_W:0]    pos_mag;
	logic [CMPW-1:0]   cnt_c;
	logic [CMPW-1:0]   pos_c;
	logic [CMPW-1:0]   mag_c;
	logic [CMPW-1:0]   offset_c;
	logic              idx_ok;
	logic [AW-1:0]     idx_slot;
	logic              cnt_full;
	logic              cnt_zero;

	// RAM port signals.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DW-1:0]     ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_ra;
	logic [AW-1:0]     ram_rb;
	logic [DW-1:0]     ram_rd_a;
	logic [DW-1:0]     ram_rd_b;
	logic [CW-1:0]     look_m1;

	logic              out_free;
	logic              resp_load;
	logic              accept;
	logic [DW-1:0]     resp_front;
	logic [DW-1:0]     resp_back;

	assign out_free  = !m_valid_q || m_tready;
	assign resp_load = (state_q == ST_RESP) && out_free;
	assign s_tready  = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_free);
	assign accept    = s_tvalid && s_tready;

	// Signed index resolution: a negative index counts back from the end.
	assign pos_neg  = pos_q[POS_W-1];
	assign pos_mag  = (POS_W+1)'(0) - {pos_q[POS_W-1], pos_q};
	assign cnt_c    = CMPW'(count_q);
	assign pos_c    = CMPW'(pos_q[POS_W-2:0]);
	assign mag_c    = CMPW'(pos_mag);
	assign idx_ok   = pos_neg ? (mag_c <= cnt_c) : (pos_c < cnt_c);
	assign offset_c = pos_neg ? (cnt_c - mag_c) : pos_c;
	assign idx_slot = wrap_add(head_q, offset_c[AW-1:0]);
	assign cnt_full = (count_q == FULL_CNT);
	assign cnt_zero = (count_q == '0);

	always_comb begin
		ex_we       = 1'b0;
		ex_waddr    = head_q;
		ex_re       = 1'b0;
		ex_ra       = head_q;
		ex_rb       = head_q;
		ex_head     = head_q;
		ex_count    = count_q;
		ex_status   = STAT_OK;
		ex_use_regs = 1'b0;
		ex_grow     = 1'b0;
		ex_cnt_m1   = '0;
		unique case (op_q)
			OP_PUSH_BACK: begin
				if (cnt_full) begin
					ex_status = STAT_FULL;
				end else begin
					ex_we    = 1'b1;
					ex_waddr = wrap_add(head_q, count_q[AW-1:0]);
					ex_count = count_q + CW'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (cnt_full) begin
					ex_status = STAT_FULL;
				end else begin
					ex_head  = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
					ex_we    = 1'b1;
					ex_waddr = ex_head;
					ex_count = count_q + CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (cnt_zero) begin
					ex_status = STAT_EMPTY;
				end else begin
					ex_count = count_q - CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (cnt_zero) begin
					ex_status = STAT_EMPTY;
				end else begin
					ex_head  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
					ex_count = count_q - CW'(1);
				end
			end
			OP_READ: begin
				// Front and back do not move; they come from the last result.
				ex_use_regs = 1'b1;
				ex_re       = 1'b1;
				ex_ra       = idx_slot;
				if (!idx_ok) begin
					ex_status = STAT_RANGE;
				end
			end
			OP_WRITE: begin
				if (idx_ok) begin
					ex_we    = 1'b1;
					ex_waddr = idx_slot;
				end else begin
					ex_status = STAT_RANGE;
				end
			end
			OP_CLEAR: begin
				ex_head  = '0;
				ex_count = '0;
			end
			OP_RESIZE: begin
				if (pos_neg) begin
					ex_status = STAT_RANGE;
				end else if (pos_c > DEPTH_C) begin
					ex_status = STAT_FULL;
				end else begin
					ex_count = pos_c[CW-1:0];
					ex_grow  = (pos_c > cnt_c);
				end
			end
			default: begin
				ex_status = STAT_OK;
			end
		endcase
		if (!ex_use_regs && !ex_grow) begin
			ex_cnt_m1 = ex_count - CW'(1);
			ex_re     = 1'b1;
			ex_ra     = ex_head;
			ex_rb     = wrap_add(ex_head, ex_cnt_m1[AW-1:0]);
		end
	end

	assign look_m1 = count_q - CW'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ex_waddr;
		ram_wdata = val_q;
		ram_re    = 1'b0;
		ram_ra    = ex_ra;
		ram_rb    = ex_rb;
		unique case (state_q)
			ST_EXEC: begin
				ram_we = ex_we;
				ram_re = ex_re;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = wrap_add(head_q, fill_q[AW-1:0]);
			end
			ST_LOOK: begin
				ram_re = 1'b1;
				ram_ra = head_q;
				ram_rb = wrap_add(head_q, look_m1[AW-1:0]);
			end
			ST_IDLE, ST_RESP: begin
				ram_re = 1'b0;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	rbd_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_ra),
		.raddr_b (ram_rb),
		.rdata_a (ram_rd_a),
		.rdata_b (ram_rd_b)
	);

	// The RAM returns old data when a slot is read as it is written, so the
	// written word is forwarded for that case.
	always_comb begin
		if (cnt_zero) begin
			resp_front = '0;
			resp_back  = '0;
		end else if (use_regs_q) begin
			resp_front = front_q;
			resp_back  = back_q;
		end else begin
			resp_front = fwd_a_q ? fwd_val_q : ram_rd_a;
			resp_back  = fwd_b_q ? fwd_val_q : ram_rd_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_PUSH_BACK;
			val_q        <= '0;
			pos_q        <= '0;
			head_q       <= '0;
			count_q      <= '0;
			fill_q       <= '0;
			status_q     <= STAT_OK;
			use_regs_q   <= 1'b0;
			rd_ok_q      <= 1'b0;
			fwd_a_q      <= 1'b0;
			fwd_b_q      <= 1'b0;
			fwd_val_q    <= '0;
			front_q      <= '0;
			back_q       <= '0;
			m_valid_q    <= 1'b0;
			out_rd_q     <= '0;
			out_front_q  <= '0;
			out_back_q   <= '0;
			out_count_q  <= '0;
			out_empty_q  <= 1'b1;
			out_status_q <= STAT_OK;
		end else begin
			if (resp_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (accept) begin
				op_q  <= op_t'(s_tuser[OP_W-1:0]);
				val_q <= s_tdata[DW-1:0];
				pos_q <= s_tdata[DW+POS_W-1:DW];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					head_q     <= ex_head;
					count_q    <= ex_count;
					status_q   <= ex_status;
					use_regs_q <= ex_use_regs;
					rd_ok_q    <= ex_use_regs && idx_ok;
					fwd_a_q    <= ex_we && (ex_waddr == ex_ra);
					fwd_b_q    <= ex_we && (ex_waddr == ex_rb);
					fwd_val_q  <= val_q;
					if (ex_grow) begin
						fill_q  <= count_q;
						state_q <= ST_FILL;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_FILL: begin
					fill_q <= fill_q + CW'(1);
					if (fill_q + CW'(1) == count_q) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					fwd_a_q <= 1'b0;
					fwd_b_q <= 1'b0;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						out_rd_q     <= rd_ok_q ? ram_rd_a : '0;
						out_front_q  <= resp_front;
						out_back_q   <= resp_back;
						out_count_q  <= count_q;
						out_empty_q  <= cnt_zero;
						out_status_q <= status_q;
						front_q      <= resp_front;
						back_q       <= resp_back;
						state_q      <= accept ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({out_empty_q, out_count_q, out_back_q, out_front_q, out_rd_q});
	assign m_tuser  = 8'({out_status_q});

	`RBD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FULL_CNT)
	`RBD_ASSERT_NOW(a_head_bound, 1'b1, head_q <= LAST_IDX)
	`RBD_ASSERT_NOW(a_fill_bound, state_q == ST_FILL, fill_q < count_q)
	`RBD_ASSERT_NEXT(a_resp_loads, (state_q == ST_RESP) && accept, m_tvalid && (state_q == ST_EXEC))

endmodule

/* rtl/rbd_ram.sv */
`timescale 1ns / 1ps

// Simple dual-read RAM: one write port, two registered read ports.
// A read at the address being written returns the old contents.
module rbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
